// File: src/tccw_pkg.sv
// Shared types and constants for the text console cell writer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

  // default window limits, handed to the top level parameters
  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_MAX_COLUMNS = 128;

  // request and result field widths
  localparam int CMD_W    = 3;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int CELL_W   = CHAR_W + ATTR_W;
  localparam int TROW_W   = 6;
  localparam int TCOL_W   = 7;
  localparam int OROW_W   = 6;
  localparam int OCOL_W   = 7;

  // width that holds any window count or position for comparisons
  localparam int CNT_W    = 9;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int ROWS_REG_W = 7;
  localparam int COLS_REG_W = 8;

  localparam logic [ROWS_REG_W-1:0] ROWS_RESET  = 7'd25;
  localparam logic [COLS_REG_W-1:0] COLS_RESET  = 8'd80;
  localparam logic [ATTR_W-1:0]     FILL_RESET  = 8'd10;
  localparam logic                  ENABLE_RESET = 1'b1;

  // control characters
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h00;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 3'd0,
    CMD_CLEAR = 3'd1,
    CMD_MOVE  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS   = 2'd0,
    REG_COLS   = 2'd1,
    REG_FILL   = 2'd2,
    REG_ENABLE = 2'd3
  } cfg_reg_t;

  // actions decided for one request
  typedef struct packed {
    logic update;   // store the new cursor
    logic wr;       // one cell write
    logic scroll;   // scroll the window up one row
    logic clear;    // blank the whole window
    logic pend;     // new wrap pending flag
  } plan_t;

endpackage

`default_nettype wire

// File: src/tccw_cell_mem.sv
// Cell store: one write port, one read port, registered read data.
// Uses tccw_pkg for the cell width.
`timescale 1ns / 1ps
`default_nettype none

module tccw_cell_mem #(
  parameter int DEPTH = 8192
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [$clog2(DEPTH)-1:0]    waddr,
  input  wire logic [tccw_pkg::CELL_W-1:0] wdata,
  input  wire logic                        re,
  input  wire logic [$clog2(DEPTH)-1:0]    raddr,
  output logic      [tccw_pkg::CELL_W-1:0] rdata
);
  import tccw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data registered when re is high
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/tccw_cfg_regs.sv
// Configuration registers and clamped window size.
// Uses tccw_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps
`default_nettype none

module tccw_cfg_regs #(
  parameter  int MAX_ROWS    = 64,
  parameter  int MAX_COLUMNS = 128,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic      [RW:0]                     win_rows,
  output logic      [CW:0]                     win_cols,
  output logic      [tccw_pkg::ATTR_W-1:0]     fill_color,
  output logic                                 enable
);
  import tccw_pkg::*;

  logic [ROWS_REG_W-1:0] rows_in_use;
  logic [COLS_REG_W-1:0] columns_in_use;
  logic [CNT_W-1:0]      rows9;
  logic [CNT_W-1:0]      cols9;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use    <= ROWS_RESET;
      columns_in_use <= COLS_RESET;
      fill_color     <= FILL_RESET;
      enable         <= ENABLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROWS:   rows_in_use    <= cfg_data[ROWS_REG_W-1:0];
        REG_COLS:   columns_in_use <= cfg_data[COLS_REG_W-1:0];
        REG_FILL:   fill_color     <= cfg_data[ATTR_W-1:0];
        REG_ENABLE: enable         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // window clamped to 2..MAX_ROWS and 1..MAX_COLUMNS
  always_comb begin
    rows9 = CNT_W'(rows_in_use);
    cols9 = CNT_W'(columns_in_use);
    if (rows9 < CNT_W'(2)) begin
      rows9 = CNT_W'(2);
    end else if (rows9 > CNT_W'(MAX_ROWS)) begin
      rows9 = CNT_W'(MAX_ROWS);
    end
    if (cols9 < CNT_W'(1)) begin
      cols9 = CNT_W'(1);
    end else if (cols9 > CNT_W'(MAX_COLUMNS)) begin
      cols9 = CNT_W'(MAX_COLUMNS);
    end
  end

  assign win_rows = (RW+1)'(rows9);
  assign win_cols = (CW+1)'(cols9);

endmodule

`default_nettype wire

// File: src/tccw_decode.sv
// Command decode: new cursor, cell write and scroll/clear decisions for one request.
// Uses tccw_pkg for command codes, control characters and the plan struct.
`timescale 1ns / 1ps
`default_nettype none

module tccw_decode #(
  parameter  int MAX_ROWS    = 64,
  parameter  int MAX_COLUMNS = 128,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
  input  wire logic [tccw_pkg::CMD_W-1:0]  cmd,
  input  wire logic [tccw_pkg::CHAR_W-1:0] chr,
  input  wire logic [tccw_pkg::TROW_W-1:0] trow,
  input  wire logic [tccw_pkg::TCOL_W-1:0] tcol,
  input  wire logic [RW-1:0]               line_cur,
  input  wire logic [CW-1:0]               col_cur,
  input  wire logic                        pend_cur,
  input  wire logic [RW:0]                 win_rows,
  input  wire logic [CW:0]                 win_cols,
  input  wire logic                        enable,
  input  wire logic [tccw_pkg::CELL_W-1:0] rd_data,
  output tccw_pkg::plan_t                  plan,
  output logic      [RW-1:0]               line_n,
  output logic      [CW-1:0]               col_n,
  output logic      [RW-1:0]               wr_row,
  output logic      [CW-1:0]               wr_col,
  output logic      [tccw_pkg::CHAR_W-1:0] wr_char,
  output logic      [tccw_pkg::CHAR_W-1:0] rd_char,
  output logic      [tccw_pkg::ATTR_W-1:0] rd_attr
);
  import tccw_pkg::*;

  logic [CNT_W-1:0] rows9, cols9, ln9, cl9, trow9, tcol9;
  logic [CNT_W-1:0] line9, col9, wrr9, wrc9, adv9;
  logic             in_win;

  always_comb begin
    rows9 = CNT_W'(win_rows);
    cols9 = CNT_W'(win_cols);
    trow9 = CNT_W'(trow);
    tcol9 = CNT_W'(tcol);
    // cursor seen through the current window
    ln9 = (CNT_W'(line_cur) < rows9) ? CNT_W'(line_cur) : rows9 - CNT_W'(1);
    cl9 = (CNT_W'(col_cur) < cols9) ? CNT_W'(col_cur) : cols9 - CNT_W'(1);
    in_win = (trow9 < rows9) && (tcol9 < cols9);

    plan    = '0;
    plan.pend = pend_cur;
    line9   = ln9;
    col9    = cl9;
    wrr9    = ln9;
    wrc9    = cl9;
    adv9    = '0;
    wr_char = chr;
    rd_char = '0;
    rd_attr = '0;

    priority if (cmd_t'(cmd) == CMD_READ) begin
      if (in_win) begin
        rd_char = rd_data[CHAR_W-1:0];
        rd_attr = rd_data[CELL_W-1:CHAR_W];
      end
    end else if (enable) begin
      plan.update = 1'b1;
      unique case (cmd_t'(cmd))
        CMD_PUT: begin
          priority if (chr == CH_NEWLINE) begin
            plan.pend = 1'b0;
            if (ln9 + CNT_W'(1) >= rows9 - CNT_W'(1)) begin
              line9       = rows9 - CNT_W'(2);
              plan.scroll = 1'b1;
            end else begin
              line9 = ln9 + CNT_W'(1);
            end
          end else if (chr == CH_RETURN) begin
            col9      = '0;
            plan.pend = 1'b0;
          end else if (chr == CH_BACKSPACE && (cl9 != '0 || ln9 != '0)) begin
            // step left, or to the end of the previous line, and blank it
            plan.pend = 1'b0;
            plan.wr   = 1'b1;
            wr_char   = CH_BLANK;
            if (cl9 != '0) begin
              col9 = cl9 - CNT_W'(1);
            end else begin
              line9 = ln9 - CNT_W'(1);
              col9  = cols9 - CNT_W'(1);
            end
            wrr9 = line9;
            wrc9 = col9;
          end else begin
            // printable: deferred wrap, scroll on the bottom row, then advance
            if (pend_cur) begin
              line9 = (ln9 + CNT_W'(1) < rows9) ? ln9 + CNT_W'(1) : rows9 - CNT_W'(1);
              col9  = '0;
            end
            if (line9 >= rows9 - CNT_W'(1)) begin
              line9       = rows9 - CNT_W'(2);
              plan.scroll = 1'b1;
            end
            plan.wr = 1'b1;
            wrr9    = line9;
            wrc9    = col9;
            adv9    = col9 + CNT_W'(1);
            if (adv9 < cols9) begin
              col9      = adv9;
              plan.pend = 1'b0;
            end else begin
              plan.pend = 1'b1;
            end
          end
        end
        CMD_CLEAR: begin
          plan.clear = 1'b1;
          line9      = '0;
          col9       = '0;
          plan.pend  = 1'b0;
        end
        CMD_MOVE: begin
          line9     = (trow9 < rows9) ? trow9 : rows9 - CNT_W'(1);
          col9      = (tcol9 < cols9) ? tcol9 : cols9 - CNT_W'(1);
          plan.pend = 1'b0;
        end
        CMD_WRITE: begin
          if (in_win) begin
            plan.wr = 1'b1;
            wrr9    = trow9;
            wrc9    = tcol9;
          end
        end
        default: ;
      endcase
    end
  end

  assign line_n = RW'(line9);
  assign col_n  = CW'(col9);
  assign wr_row = RW'(wrr9);
  assign wr_col = CW'(wrc9);

endmodule

`default_nettype wire

// File: src/text_console_cell_writer_core.sv
// Top level of the text console cell writer: request capture, sequencer and cell store.
// Depends on tccw_pkg, tccw_cfg_regs, tccw_decode and tccw_cell_mem.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken when start is high and busy is low; its result shows on the
// result ports for exactly one cycle with done high, and cannot be held off.
// Put character (no scroll), move, write at position and read pass through one
// decode state that reads, modifies and writes the cell store, then return to idle
// with done high, where the next request may already be taken. A put that scrolls
// walks the window once, one cell per cycle through the single write port: it copies
// each row up, then blanks the bottom row. Clear blanks the window one cell per cycle.
// Reading a cell that was never written since reset returns an undefined value; issue
// a clear first. MAX_ROWS ranges over 2..64, MAX_COLUMNS over 1..128.
module text_console_cell_writer_core #(
  parameter  int MAX_ROWS    = tccw_pkg::DEF_MAX_ROWS,
  parameter  int MAX_COLUMNS = tccw_pkg::DEF_MAX_COLUMNS,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [tccw_pkg::CMD_W-1:0]      command,
  input  wire logic [tccw_pkg::CHAR_W-1:0]     char_code,
  input  wire logic [tccw_pkg::TROW_W-1:0]     target_row,
  input  wire logic [tccw_pkg::TCOL_W-1:0]     target_column,
  output logic                                 done,
  output logic      [tccw_pkg::OROW_W-1:0]     cursor_row,
  output logic      [tccw_pkg::OCOL_W-1:0]     cursor_column,
  output logic      [tccw_pkg::CHAR_W-1:0]     cell_char,
  output logic      [tccw_pkg::ATTR_W-1:0]     cell_attr,
  output logic                                 scrolled,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tccw_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_COPY   = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_FILL   = 6'b010000,
    S_FINAL  = 6'b100000
  } state_t;

  state_t state, state_next;

  // configuration
  logic [RW:0]       win_rows;
  logic [CW:0]       win_cols;
  logic [ATTR_W-1:0] fill_color;
  logic              enable;

  // captured request and cursor
  logic [CMD_W-1:0]  cmd_q;
  logic [CHAR_W-1:0] char_q;
  logic [TROW_W-1:0] trow_q;
  logic [TCOL_W-1:0] tcol_q;
  logic [RW-1:0]     line_s;
  logic [CW-1:0]     col_s;
  logic              pend_s;

  // decode results
  plan_t             plan;
  logic [RW-1:0]     line_n, wr_row;
  logic [CW-1:0]     col_n, wr_col;
  logic [CHAR_W-1:0] wr_char, rd_char;
  logic [ATTR_W-1:0] rd_attr;

  // walker and deferred cell write
  logic [RW-1:0]     wk_row;
  logic [CW-1:0]     wk_col;
  logic              cp_valid;
  logic [AW-1:0]     cp_addr;
  logic              dw_pend;
  logic [RW-1:0]     dw_row;
  logic [CW-1:0]     dw_col;
  logic [CHAR_W-1:0] dw_char;
  logic              last_col, last_copy_row, last_row;

  // memory ports
  logic              accept;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, rd_data;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(int'(r) * MAX_COLUMNS + int'(c));
  endfunction

  tccw_cfg_regs #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .win_rows   (win_rows),
    .win_cols   (win_cols),
    .fill_color (fill_color),
    .enable     (enable)
  );

  tccw_decode #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_decode (
    .cmd      (cmd_q),
    .chr      (char_q),
    .trow     (trow_q),
    .tcol     (tcol_q),
    .line_cur (line_s),
    .col_cur  (col_s),
    .pend_cur (pend_s),
    .win_rows (win_rows),
    .win_cols (win_cols),
    .enable   (enable),
    .rd_data  (rd_data),
    .plan     (plan),
    .line_n   (line_n),
    .col_n    (col_n),
    .wr_row   (wr_row),
    .wr_col   (wr_col),
    .wr_char  (wr_char),
    .rd_char  (rd_char),
    .rd_attr  (rd_attr)
  );

  tccw_cell_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // walker end conditions
  assign last_col      = ((CW+1)'(wk_col) == win_cols - (CW+1)'(1));
  assign last_copy_row = ((RW+1)'(wk_row) == win_rows - (RW+1)'(2));
  assign last_row      = ((RW+1)'(wk_row) == win_rows - (RW+1)'(1));

  // read port: target cell at accept, source row while copying
  always_comb begin
    mem_re    = accept || (state == S_COPY);
    mem_raddr = cell_addr(RW'(target_row), CW'(target_column));
    if (state == S_COPY) begin
      mem_raddr = cell_addr(wk_row + RW'(1), wk_col);
    end
  end

  // write port: copy data, blanks, deferred character, or the decode write
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cp_addr;
    mem_wdata = rd_data;
    priority if (cp_valid) begin
      mem_we = 1'b1;
    end else if (state == S_FILL) begin
      mem_we    = 1'b1;
      mem_waddr = cell_addr(wk_row, wk_col);
      mem_wdata = {fill_color, CH_BLANK};
    end else if (state == S_FINAL && dw_pend) begin
      mem_we    = 1'b1;
      mem_waddr = cell_addr(dw_row, dw_col);
      mem_wdata = {fill_color, dw_char};
    end else if (state == S_DECODE && plan.wr && !plan.scroll) begin
      mem_we    = 1'b1;
      mem_waddr = cell_addr(wr_row, wr_col);
      mem_wdata = {fill_color, wr_char};
    end else begin
      mem_we = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_DECODE;
      end
      S_DECODE: begin
        priority if (plan.clear) state_next = S_FILL;
        else if (plan.scroll)    state_next = S_COPY;
        else                     state_next = S_IDLE;
      end
      S_COPY: begin
        if (last_col && last_copy_row) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_FILL;
      S_FILL: begin
        if (last_col && last_row) state_next = S_FINAL;
      end
      S_FINAL: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      cp_valid <= 1'b0;
      line_s   <= '0;
      col_s    <= '0;
      pend_s   <= 1'b0;
    end else begin
      state    <= state_next;
      done     <= (state == S_DECODE && !plan.scroll && !plan.clear) || (state == S_FINAL);
      cp_valid <= (state == S_COPY);
      if (state == S_DECODE && plan.update) begin
        line_s <= line_n;
        col_s  <= col_n;
        pend_s <= plan.pend;
      end
    end
  end

  // request capture, results and walker counters
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= command;
      char_q <= char_code;
      trow_q <= target_row;
      tcol_q <= target_column;
    end
    unique case (state)
      S_DECODE: begin
        cursor_row    <= OROW_W'(line_n);
        cursor_column <= OCOL_W'(col_n);
        cell_char     <= rd_char;
        cell_attr     <= rd_attr;
        scrolled      <= plan.scroll;
        dw_pend       <= plan.wr && plan.scroll;
        dw_row        <= wr_row;
        dw_col        <= wr_col;
        dw_char       <= wr_char;
        wk_row        <= '0;
        wk_col        <= '0;
      end
      S_COPY: begin
        cp_addr <= cell_addr(wk_row, wk_col);
        if (last_col) begin
          wk_col <= '0;
          if (!last_copy_row) wk_row <= wk_row + RW'(1);
        end else begin
          wk_col <= wk_col + CW'(1);
        end
      end
      S_DRAIN: begin
        wk_row <= RW'(win_rows - (RW+1)'(1));
        wk_col <= '0;
      end
      S_FILL: begin
        if (last_col) begin
          wk_col <= '0;
          if (!last_row) wk_row <= wk_row + RW'(1);
        end else begin
          wk_col <= wk_col + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // checks
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result strobe without a request in flight");

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_DECODE)) else $error("accepted request not decoded");

  a_copy_pipe: assert property (@(posedge clk) disable iff (rst)
    cp_valid |-> (state == S_COPY || state == S_DRAIN)) else $error("stray copy write");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we) else $error("cell store written while idle");

endmodule

`default_nettype wire
